[hw/rtl/csvt_pkg.sv]
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int NUM_RES = 3;

    localparam logic [1:0] MODE_UNQ   = 2'd0;
    localparam logic [1:0] MODE_QUOTE = 2'd1;
    localparam logic [1:0] MODE_QSEEN = 2'd2;
    localparam logic [1:0] MODE_SKIP  = 2'd3;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_cnt;

    typedef struct packed {
        logic  has_byte;
        t_byte field_byte;
        logic  field_end;
        logic  row_end;
        logic  last_of_run;
    } t_res;

    typedef struct packed {
        logic       line_open;
        logic       odd;
        logic [1:0] mode;
        logic       empty;
        logic       cr;
    } t_state;

    localparam t_state ST_RESET = '{
        line_open: 1'b0, odd: 1'b0, mode: MODE_UNQ, empty: 1'b1, cr: 1'b0
    };

    localparam t_res RES_ROW_END = '{
        has_byte: 1'b0, field_byte: 8'h00, field_end: 1'b1, row_end: 1'b1,
        last_of_run: 1'b0
    };

endpackage

[hw/rtl/csvt_if.sv]
interface csvt_in_if;
    logic                 valid;
    logic                 ready;
    csvt_pkg::t_byte      text_byte;
    logic                 end_of_file;

    modport source (output valid, text_byte, end_of_file, input ready);
    modport sink (input valid, text_byte, end_of_file, output ready);
endinterface

interface csvt_out_if;
    logic                 valid;
    logic                 ready;
    logic                 has_byte;
    csvt_pkg::t_byte      field_byte;
    logic                 field_end;
    logic                 row_end;
    logic                 last_of_run;

    modport source (output valid, has_byte, field_byte, field_end, row_end, last_of_run,
                    input ready);
    modport sink (input valid, has_byte, field_byte, field_end, row_end, last_of_run,
                  output ready);
endinterface

[hw/rtl/csvt_step.sv]
module csvt_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  csvt_pkg::t_byte  i_byte,
    input  logic             i_eof,
    input  csvt_pkg::t_byte  i_delim,
    output csvt_pkg::t_res   o_res [csvt_pkg::NUM_RES],
    output csvt_pkg::t_cnt   o_cnt
);
    import csvt_pkg::*;

    typedef struct packed {
        logic       vld;
        t_res       r;
        logic [1:0] mode;
        logic       empty;
    } t_pres;

    function automatic t_pres parse_byte(logic [1:0] mode, logic empty, t_byte b,
                                         t_byte delim);
        t_pres      p;
        logic [1:0] m;
        p       = '0;
        p.mode  = mode;
        p.empty = empty;
        m       = mode;
        if (m == MODE_QSEEN && b == CH_QUOTE) begin
            p.vld          = 1'b1;
            p.r.has_byte   = 1'b1;
            p.r.field_byte = CH_QUOTE;
            p.empty        = 1'b0;
            p.mode         = MODE_QUOTE;
        end else begin
            if (m == MODE_QSEEN) begin
                m      = MODE_UNQ;
                p.mode = MODE_UNQ;
            end
            if (m == MODE_SKIP) begin
                p.vld = 1'b0;
            end else if (m == MODE_QUOTE) begin
                if (b == CH_QUOTE) begin
                    p.mode = MODE_QSEEN;
                end else begin
                    p.vld          = 1'b1;
                    p.r.has_byte   = 1'b1;
                    p.r.field_byte = b;
                    p.empty        = 1'b0;
                end
            end else if (b == CH_QUOTE && empty) begin
                p.mode = MODE_QUOTE;
            end else if (b == delim) begin
                p.vld         = 1'b1;
                p.r.field_end = 1'b1;
                p.empty       = 1'b1;
            end else if (b == CH_CR || b == CH_LF) begin
                p.vld  = 1'b1;
                p.r    = RES_ROW_END;
                p.mode = MODE_SKIP;
            end else begin
                p.vld          = 1'b1;
                p.r.has_byte   = 1'b1;
                p.r.field_byte = b;
                p.empty        = 1'b0;
            end
        end
        return p;
    endfunction

    t_state r_st;
    t_state n_st;
    t_state st;
    t_pres  p_cr;
    t_pres  p_b;
    logic   v [NUM_RES];
    t_res   s [NUM_RES];
    t_cnt   cnt;

    always_comb begin
        st     = r_st;
        p_cr   = '0;
        p_b    = '0;
        for (int i = 0; i < NUM_RES; i++) begin
            v[i] = 1'b0;
            s[i] = '0;
        end
        if (r_st.line_open || (i_byte != CH_CR && i_byte != CH_LF)) begin
            if (!r_st.line_open) begin
                st           = ST_RESET;
                st.line_open = 1'b1;
            end
            if (i_byte == CH_LF && !st.odd) begin
                v[0] = (st.mode != MODE_SKIP);
                s[0] = RES_ROW_END;
                st   = ST_RESET;
            end else begin
                st.odd = st.odd ^ (i_byte == CH_QUOTE);
                if (st.cr) begin
                    p_cr     = parse_byte(st.mode, st.empty, CH_CR, i_delim);
                    v[0]     = p_cr.vld;
                    s[0]     = p_cr.r;
                    st.mode  = p_cr.mode;
                    st.empty = p_cr.empty;
                    st.cr    = 1'b0;
                end
                if (i_byte == CH_CR && st.mode != MODE_SKIP) begin
                    st.cr = 1'b1;
                end else begin
                    p_b      = parse_byte(st.mode, st.empty, i_byte, i_delim);
                    v[1]     = p_b.vld;
                    s[1]     = p_b.r;
                    st.mode  = p_b.mode;
                    st.empty = p_b.empty;
                end
                if (i_eof) begin
                    v[2] = (st.mode != MODE_SKIP);
                    s[2] = RES_ROW_END;
                    st   = ST_RESET;
                end
            end
        end
        n_st = st;
    end

    always_comb begin
        cnt = '0;
        for (int i = 0; i < NUM_RES; i++) begin
            o_res[i] = '0;
        end
        for (int i = 0; i < NUM_RES; i++) begin
            if (v[i]) begin
                o_res[cnt] = s[i];
                cnt        = cnt + t_cnt'(1);
            end
        end
        if (cnt != '0) begin
            o_res[cnt - t_cnt'(1)].last_of_run = 1'b1;
        end
        o_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

[hw/rtl/csvt_obuf.sv]
module csvt_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  csvt_pkg::t_res  i_res [csvt_pkg::NUM_RES],
    input  csvt_pkg::t_cnt  i_cnt,
    input  logic            i_pop,
    output logic            o_valid,
    output csvt_pkg::t_res  o_head,
    output logic            o_can_load
);
    import csvt_pkg::*;

    t_res r_buf [NUM_RES];
    t_cnt r_cnt;

    assign o_valid    = (r_cnt != '0);
    assign o_head     = r_buf[0];
    assign o_can_load = (r_cnt == '0) || (r_cnt == t_cnt'(1) && i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (i_pop && r_cnt != '0) begin
            r_cnt <= r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < NUM_RES; i++) begin
                r_buf[i] <= i_res[i];
            end
        end else if (i_pop) begin
            for (int i = 0; i < NUM_RES - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

endmodule

[hw/rtl/csv_stream_tokenizer_unit.sv]
// Delimited-text tokenizer, one file byte per input transfer.
// Input channel i_in: text_byte and end_of_file, valid/ready.
// Output channel o_out: has_byte/field_byte, field_end, row_end and
// last_of_run, valid/ready; last_of_run marks the final result of a byte.
// Config: i_cfg_we writes i_cfg_data into the delimiter (comma after reset);
// write it only while the block is idle.
// Results of a byte are registered in the output buffer and appear on o_out the cycle after its transfer.
// Throughput: a byte giving zero or one result transfers every cycle while the receiver
// does not stall; a byte giving more results (at most three) holds the output buffer
// until they have left, and the next byte is taken in the cycle its last result leaves.
// Reset (synchronous, i_rst_n low) empties the output buffer, closes any open
// line and restores the comma delimiter.
// When the receiver stalls, the current result holds on o_out and i_in.ready
// drops; no result is lost or repeated.
module csv_stream_tokenizer_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csvt_in_if.sink          i_in,
    csvt_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  csvt_pkg::t_byte  i_cfg_data
);
    import csvt_pkg::*;

    t_byte r_delim;
    t_res  res [NUM_RES];
    t_cnt  cnt;
    t_res  head;
    logic  can_load;
    logic  accept;
    logic  out_valid;

    assign accept = i_in.valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= CH_COMMA;
        end else if (i_cfg_we) begin
            r_delim <= i_cfg_data;
        end
    end

    csvt_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.text_byte),
        .i_eof    (i_in.end_of_file),
        .i_delim  (r_delim),
        .o_res    (res),
        .o_cnt    (cnt)
    );

    csvt_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .i_cnt      (cnt),
        .i_pop      (o_out.ready),
        .o_valid    (out_valid),
        .o_head     (head),
        .o_can_load (can_load)
    );

    assign i_in.ready        = can_load;
    assign o_out.valid       = out_valid;
    assign o_out.has_byte    = head.has_byte;
    assign o_out.field_byte  = head.field_byte;
    assign o_out.field_end   = head.field_end;
    assign o_out.row_end     = head.row_end;
    assign o_out.last_of_run = head.last_of_run;

endmodule

[hw/rtl/csvt_checker.sv]
module csvt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_has_byte,
    input csvt_pkg::t_byte i_field_byte,
    input logic            i_field_end,
    input logic            i_row_end,
    input logic            i_last_of_run
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_field_byte))
        else $error("output dropped during stall");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_out_valid)
        else $error("run ended without last_of_run");

    a_row_has_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_row_end |-> i_field_end && !i_has_byte)
        else $error("row end without field end");

    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_byte |-> i_field_byte == 8'h00)
        else $error("field_byte set without has_byte");

endmodule

bind csv_stream_tokenizer_unit csvt_checker u_csvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_has_byte    (o_out.has_byte),
    .i_field_byte  (o_out.field_byte),
    .i_field_end   (o_out.field_end),
    .i_row_end     (o_out.row_end),
    .i_last_of_run (o_out.last_of_run)
);
